// File: rtl/pdfi_pkg.sv
// pdfi_pkg: constants, breakpoint tables, payload types and helpers
// for the pvt derating factor interpolator; used by every rtl file
package pdfi_pkg;

  localparam int FRAC_BITS   = 20;
  localparam int VOLT_POINTS = 7;
  localparam int TEMP_POINTS = 15;
  localparam int MICRO       = 1000000;

  localparam int VOLT_W   = 11;
  localparam int TEMP_W   = 12;
  localparam int CORNER_W = 2;
  localparam int FACTOR_W = 22;

  // segment arithmetic widths
  localparam int BASE_W  = 28;
  localparam int DEN_W   = 28;
  localparam int DY_W    = 18;
  localparam int OFS_W   = 8;
  localparam int PROD_W  = DY_W + OFS_W + 1;
  localparam int SUM_W   = BASE_W + 2;
  localparam int QUO_W   = FRAC_BITS + 1;
  localparam int NUM_W   = DEN_W + QUO_W;
  localparam int LANE_LAT = QUO_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CORNER_W-1:0] {
    CORNER_SLOW    = 2'd0,
    CORNER_TYP     = 2'd1,
    CORNER_FAST    = 2'd2,
    CORNER_INVALID = 2'd3
  } corner_t;

  localparam int VOLT_X [VOLT_POINTS] = '{1080, 1120, 1160, 1200, 1240, 1280, 1320};
  localparam int VOLT_Y [VOLT_POINTS] =
    '{1121557, 1075332, 1035161, 1000000, 968480, 940065, 914482};
  localparam int TEMP_X [TEMP_POINTS] =
    '{-250, -150, 0, 150, 250, 350, 450, 550, 650, 750, 850, 950, 1050, 1150, 1250};
  localparam int TEMP_Y [TEMP_POINTS] =
    '{897498, 917532, 948338, 979213, 1000000, 1020305, 1040540, 1061831,
      1082983, 1103817, 1124124, 1144245, 1164563, 1184370, 1204966};
  localparam int CORNER_SLOW_Y = 1174235;
  localparam int CORNER_TYP_Y  = 1000000;
  localparam int CORNER_FAST_Y = 876148;

  // one interpolation job: factor = round(((base + dy * ofs) << FRAC_BITS) / den)
  typedef struct packed {
    logic [BASE_W-1:0]      base;
    logic signed [DY_W-1:0] dy;
    logic [OFS_W-1:0]       ofs;
    logic [DEN_W-1:0]       den;
  } seg_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] proc_factor;
    logic                volt_ok;
    logic                temp_ok;
    logic                proc_ok;
  } side_t;

  typedef struct packed {
    seg_t  volt;
    seg_t  temp;
    side_t side;
  } item_t;

  // millionths to rounded fixed point, masked to the factor width
  function automatic logic [FACTOR_W-1:0] to_factor(input int y);
    longint s;
    s = (longint'(y) <<< FRAC_BITS) + longint'(MICRO / 2);
    return FACTOR_W'(s / MICRO);
  endfunction

endpackage

// File: rtl/pdfi_front.sv
// pdfi_front: accepts input items, finds the table segments and the
// process constant, and pushes one classified record into the queue; uses pdfi_pkg
module pdfi_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pdfi_pkg::VOLT_W-1:0]         in_voltage_mv,
  input  logic signed [pdfi_pkg::TEMP_W-1:0]  in_temperature_decideg,
  input  logic [pdfi_pkg::CORNER_W-1:0]       in_process_corner,
  input  logic                                q_full,
  output logic                                q_push,
  output pdfi_pkg::item_t                     q_data
);

  pdfi_pkg::seg_t              vseg;
  pdfi_pkg::seg_t              tseg;
  pdfi_pkg::side_t             side;
  logic                        volt_ok;
  logic                        temp_ok;
  logic [pdfi_pkg::FACTOR_W-1:0] proc_factor;
  logic                        proc_ok;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // out of span leaves a zero numerator, so the lane returns zero
  always_comb begin
    vseg.base = '0;
    vseg.dy   = '0;
    vseg.ofs  = '0;
    vseg.den  = pdfi_pkg::DEN_W'(1);
    volt_ok   = 1'b0;
    for (int i = pdfi_pkg::VOLT_POINTS - 2; i >= 0; i--) begin
      if (int'(in_voltage_mv) >= pdfi_pkg::VOLT_X[i] &&
          int'(in_voltage_mv) <= pdfi_pkg::VOLT_X[i+1] &&
          pdfi_pkg::VOLT_X[i+1] > pdfi_pkg::VOLT_X[i]) begin
        vseg.base = pdfi_pkg::BASE_W'(pdfi_pkg::VOLT_Y[i] *
                    (pdfi_pkg::VOLT_X[i+1] - pdfi_pkg::VOLT_X[i]));
        vseg.dy   = pdfi_pkg::DY_W'(pdfi_pkg::VOLT_Y[i+1] - pdfi_pkg::VOLT_Y[i]);
        vseg.ofs  = pdfi_pkg::OFS_W'(int'(in_voltage_mv) - pdfi_pkg::VOLT_X[i]);
        vseg.den  = pdfi_pkg::DEN_W'(pdfi_pkg::MICRO *
                    (pdfi_pkg::VOLT_X[i+1] - pdfi_pkg::VOLT_X[i]));
        volt_ok   = 1'b1;
      end
    end
  end

  always_comb begin
    tseg.base = '0;
    tseg.dy   = '0;
    tseg.ofs  = '0;
    tseg.den  = pdfi_pkg::DEN_W'(1);
    temp_ok   = 1'b0;
    for (int i = pdfi_pkg::TEMP_POINTS - 2; i >= 0; i--) begin
      if (int'(in_temperature_decideg) >= pdfi_pkg::TEMP_X[i] &&
          int'(in_temperature_decideg) <= pdfi_pkg::TEMP_X[i+1] &&
          pdfi_pkg::TEMP_X[i+1] > pdfi_pkg::TEMP_X[i]) begin
        tseg.base = pdfi_pkg::BASE_W'(pdfi_pkg::TEMP_Y[i] *
                    (pdfi_pkg::TEMP_X[i+1] - pdfi_pkg::TEMP_X[i]));
        tseg.dy   = pdfi_pkg::DY_W'(pdfi_pkg::TEMP_Y[i+1] - pdfi_pkg::TEMP_Y[i]);
        tseg.ofs  = pdfi_pkg::OFS_W'(int'(in_temperature_decideg) - pdfi_pkg::TEMP_X[i]);
        tseg.den  = pdfi_pkg::DEN_W'(pdfi_pkg::MICRO *
                    (pdfi_pkg::TEMP_X[i+1] - pdfi_pkg::TEMP_X[i]));
        temp_ok   = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (pdfi_pkg::corner_t'(in_process_corner))
      pdfi_pkg::CORNER_SLOW: begin
        proc_factor = pdfi_pkg::to_factor(pdfi_pkg::CORNER_SLOW_Y);
        proc_ok     = 1'b1;
      end
      pdfi_pkg::CORNER_TYP: begin
        proc_factor = pdfi_pkg::to_factor(pdfi_pkg::CORNER_TYP_Y);
        proc_ok     = 1'b1;
      end
      pdfi_pkg::CORNER_FAST: begin
        proc_factor = pdfi_pkg::to_factor(pdfi_pkg::CORNER_FAST_Y);
        proc_ok     = 1'b1;
      end
      default: begin
        proc_factor = '0;
        proc_ok     = 1'b0;
      end
    endcase
  end

  assign side   = '{proc_factor, volt_ok, temp_ok, proc_ok};
  assign q_data = '{vseg, tseg, side};

endmodule

// File: rtl/pdfi_queue.sv
// pdfi_queue: short fifo of classified records between front and back
// depth from pdfi_pkg::QUEUE_DEPTH; uses pdfi_pkg
module pdfi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pdfi_pkg::item_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output pdfi_pkg::item_t head
);

  pdfi_pkg::item_t                 entry_r [pdfi_pkg::QUEUE_DEPTH];
  logic [pdfi_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [pdfi_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [pdfi_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full  = count_r == pdfi_pkg::QCNT_W'(pdfi_pkg::QUEUE_DEPTH);
  assign empty = count_r == '0;
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pdfi_pkg::QPTR_W'(pdfi_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pdfi_pkg::QPTR_W'(pdfi_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty)) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == pdfi_pkg::QCNT_W'($past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// File: rtl/pdfi_lane.sv
// pdfi_lane: one factor lane, multiply, numerator build and a pipelined
// restoring divider, one quotient bit per stage; uses pdfi_pkg
module pdfi_lane (
  input  logic                         clk,
  input  logic                         en,
  input  pdfi_pkg::seg_t               seg,
  output logic [pdfi_pkg::QUO_W-1:0]   quo
);

  logic signed [pdfi_pkg::PROD_W-1:0] prod_r;
  logic [pdfi_pkg::BASE_W-1:0]        base_r;
  logic [pdfi_pkg::DEN_W-1:0]         den0_r;
  logic signed [pdfi_pkg::SUM_W-1:0]  sum;
  logic [pdfi_pkg::BASE_W-1:0]        num;

  logic [pdfi_pkg::NUM_W-1:0] rem_r [pdfi_pkg::QUO_W];
  logic [pdfi_pkg::DEN_W-1:0] den_r [pdfi_pkg::QUO_W];
  logic [pdfi_pkg::QUO_W-1:0] quo_r [pdfi_pkg::QUO_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= seg.dy * $signed({1'b0, seg.ofs});
      base_r <= seg.base;
      den0_r <= seg.den;
    end
  end

  assign sum = $signed({2'b00, base_r}) + pdfi_pkg::SUM_W'(prod_r);
  assign num = sum[pdfi_pkg::SUM_W-1] ? '0 : sum[pdfi_pkg::BASE_W-1:0];

  // rounding half added before the divide
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (pdfi_pkg::NUM_W'(num) << pdfi_pkg::FRAC_BITS) +
                  pdfi_pkg::NUM_W'(den0_r >> 1);
      den_r[0] <= den0_r;
      quo_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < pdfi_pkg::QUO_W; k++) begin : g_div
    logic [pdfi_pkg::NUM_W-1:0] dsh;
    logic                       ge;

    assign dsh = pdfi_pkg::NUM_W'(den_r[k]) << (pdfi_pkg::QUO_W - 1 - k);
    assign ge  = rem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= {quo_r[k][pdfi_pkg::QUO_W-2:0], ge};
      end
    end

    if (k < pdfi_pkg::QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign quo = quo_r[pdfi_pkg::QUO_W];

endmodule

// File: rtl/pdfi_back.sv
// pdfi_back: pops classified records, runs the voltage and temperature
// lanes in lockstep and holds the result at the output; uses pdfi_pkg, pdfi_lane
module pdfi_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  pdfi_pkg::item_t                 q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pdfi_pkg::FACTOR_W-1:0]   out_voltage_factor,
  output logic [pdfi_pkg::FACTOR_W-1:0]   out_temperature_factor,
  output logic [pdfi_pkg::FACTOR_W-1:0]   out_process_factor,
  output logic                            out_voltage_ok,
  output logic                            out_temperature_ok,
  output logic                            out_process_ok
);

  logic [pdfi_pkg::LANE_LAT-1:0] v_r;
  pdfi_pkg::side_t               side_r [pdfi_pkg::LANE_LAT];
  logic                          adv;
  logic [pdfi_pkg::QUO_W-1:0]    vquo;
  logic [pdfi_pkg::QUO_W-1:0]    tquo;

  // whole pipeline holds while the last stage waits
  assign adv   = !v_r[pdfi_pkg::LANE_LAT-1] || out_ready;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[pdfi_pkg::LANE_LAT-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= q_head.side;
      for (int i = 1; i < pdfi_pkg::LANE_LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  pdfi_lane u_volt_lane (
    .clk (clk),
    .en  (adv),
    .seg (q_head.volt),
    .quo (vquo)
  );

  pdfi_lane u_temp_lane (
    .clk (clk),
    .en  (adv),
    .seg (q_head.temp),
    .quo (tquo)
  );

  assign out_valid              = v_r[pdfi_pkg::LANE_LAT-1];
  assign out_voltage_factor     = pdfi_pkg::FACTOR_W'(vquo);
  assign out_temperature_factor = pdfi_pkg::FACTOR_W'(tquo);
  assign out_process_factor     = side_r[pdfi_pkg::LANE_LAT-1].proc_factor;
  assign out_voltage_ok         = side_r[pdfi_pkg::LANE_LAT-1].volt_ok;
  assign out_temperature_ok     = side_r[pdfi_pkg::LANE_LAT-1].temp_ok;
  assign out_process_ok         = side_r[pdfi_pkg::LANE_LAT-1].proc_ok;

  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !q_pop) else $error("pop during output stall");

  a_volt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_voltage_ok |-> out_voltage_factor == '0)
    else $error("voltage factor nonzero out of span");

  a_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_temperature_ok |-> out_temperature_factor == '0)
    else $error("temperature factor nonzero out of span");

  a_proc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_process_ok |-> out_process_factor == '0)
    else $error("process factor nonzero for invalid corner");

endmodule

// File: rtl/pvt_derating_factor_interpolator.sv
// pvt_derating_factor_interpolator: top level, front classifier, queue
// and arithmetic back end; uses pdfi_pkg, pdfi_front, pdfi_queue, pdfi_back
//
// Takes one item per cycle while in_ready is high and returns one result
// per item, in order. Each item passes the queue and then one multiply
// stage, one numerator stage and a 21-stage restoring divider per factor,
// with the voltage and temperature lanes running side by side. A four-entry
// queue sits behind the input, so in_ready drops only when the queue is
// full, which happens after a sustained output stall. No configuration, no
// clearing pass; the block is ready as soon as reset is released.
module pvt_derating_factor_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pdfi_pkg::VOLT_W-1:0]         in_voltage_mv,
  input  logic signed [pdfi_pkg::TEMP_W-1:0]  in_temperature_decideg,
  input  logic [pdfi_pkg::CORNER_W-1:0]       in_process_corner,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pdfi_pkg::FACTOR_W-1:0]       out_voltage_factor,
  output logic [pdfi_pkg::FACTOR_W-1:0]       out_temperature_factor,
  output logic [pdfi_pkg::FACTOR_W-1:0]       out_process_factor,
  output logic                                out_voltage_ok,
  output logic                                out_temperature_ok,
  output logic                                out_process_ok
);

  logic            q_full;
  logic            q_push;
  logic            q_empty;
  logic            q_pop;
  pdfi_pkg::item_t q_data;
  pdfi_pkg::item_t q_head;

  pdfi_front u_front (
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_voltage_mv          (in_voltage_mv),
    .in_temperature_decideg (in_temperature_decideg),
    .in_process_corner      (in_process_corner),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_data                 (q_data)
  );

  pdfi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pdfi_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_head                 (q_head),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_voltage_factor     (out_voltage_factor),
    .out_temperature_factor (out_temperature_factor),
    .out_process_factor     (out_process_factor),
    .out_voltage_ok         (out_voltage_ok),
    .out_temperature_ok     (out_temperature_ok),
    .out_process_ok         (out_process_ok)
  );

endmodule

// File: bench/pvt_derating_factor_interpolator_test.sv
// pvt_derating_factor_interpolator_test: self-checking bench for the pvt derating
// factor interpolator; directed edge items, then random traffic checked in order
// against an interpolation predictor. depends on pdfi_pkg and the rtl top only
`timescale 1ns / 100ps

module pvt_derating_factor_interpolator_test;

  localparam int STALL_LIMIT = 2000;
  localparam int MILLION = 1000000;
  localparam int MV_PTS = 7;
  localparam int DC_PTS = 15;

  // breakpoints in mV and decidegrees, values in millionths
  localparam int MV_BP [MV_PTS] = '{1080, 1120, 1160, 1200, 1240, 1280, 1320};
  localparam int MV_VAL [MV_PTS] =
    '{1121557, 1075332, 1035161, 1000000, 968480, 940065, 914482};
  localparam int DC_BP [DC_PTS] =
    '{-250, -150, 0, 150, 250, 350, 450, 550, 650, 750, 850, 950, 1050, 1150, 1250};
  localparam int DC_VAL [DC_PTS] =
    '{897498, 917532, 948338, 979213, 1000000, 1020305, 1040540, 1061831,
      1082983, 1103817, 1124124, 1144245, 1164563, 1184370, 1204966};
  localparam int CORNER_VAL [3] = '{1174235, 1000000, 876148};

  typedef struct packed {
    logic [pdfi_pkg::FACTOR_W-1:0] volt_f;
    logic [pdfi_pkg::FACTOR_W-1:0] temp_f;
    logic [pdfi_pkg::FACTOR_W-1:0] proc_f;
    logic                          volt_ok;
    logic                          temp_ok;
    logic                          proc_ok;
  } factors_t;

  class derating_ledger;
    factors_t owed_factors[$];
    int errors;
    int checked;
    int volt_hits;
    int temp_hits;
    int bad_corners;

    function new();
      errors = 0;
      checked = 0;
      volt_hits = 0;
      temp_hits = 0;
      bad_corners = 0;
    endfunction

    function automatic logic [pdfi_pkg::FACTOR_W-1:0] round_q(longint num, longint den);
      longint q;
      q = ((num <<< pdfi_pkg::FRAC_BITS) + den / 2) / den;
      return q[pdfi_pkg::FACTOR_W-1:0];
    endfunction

    function automatic bit interpolate(bit on_temp, int v,
                                       output logic [pdfi_pkg::FACTOR_W-1:0] f);
      int n;
      int x1;
      int x2;
      longint y1;
      longint y2;
      longint dx;
      longint num;
      f = '0;
      n = on_temp ? DC_PTS : MV_PTS;
      for (int i = 0; i + 1 < n; i++) begin
        x1 = on_temp ? DC_BP[i] : MV_BP[i];
        x2 = on_temp ? DC_BP[i+1] : MV_BP[i+1];
        y1 = longint'(on_temp ? DC_VAL[i] : MV_VAL[i]);
        y2 = longint'(on_temp ? DC_VAL[i+1] : MV_VAL[i+1]);
        if (x1 <= v && v <= x2) begin
          dx = longint'(x2 - x1);
          num = y1 * dx + (y2 - y1) * longint'(v - x1);
          if (num < 0) num = 0;
          f = round_q(num, longint'(MILLION) * dx);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [pdfi_pkg::VOLT_W-1:0] v,
                               logic signed [pdfi_pkg::TEMP_W-1:0] t,
                               logic [pdfi_pkg::CORNER_W-1:0] c);
      factors_t e;
      e.volt_ok = interpolate(1'b0, int'(v), e.volt_f);
      e.temp_ok = interpolate(1'b1, int'(t), e.temp_f);
      if (pdfi_pkg::corner_t'(c) != pdfi_pkg::CORNER_INVALID) begin
        e.proc_f = round_q(longint'(CORNER_VAL[c]), longint'(MILLION));
        e.proc_ok = 1'b1;
      end else begin
        e.proc_f = '0;
        e.proc_ok = 1'b0;
        bad_corners++;
      end
      if (e.volt_ok) volt_hits++;
      if (e.temp_ok) temp_hits++;
      owed_factors.push_back(e);
    endfunction

    function void check_factors(factors_t got);
      factors_t e;
      if (owed_factors.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      e = owed_factors.pop_front();
      checked++;
      if (got.volt_f !== e.volt_f) begin
        $error("voltage_factor: expected %0d, got %0d", e.volt_f, got.volt_f);
        errors++;
      end
      if (got.temp_f !== e.temp_f) begin
        $error("temperature_factor: expected %0d, got %0d", e.temp_f, got.temp_f);
        errors++;
      end
      if (got.proc_f !== e.proc_f) begin
        $error("process_factor: expected %0d, got %0d", e.proc_f, got.proc_f);
        errors++;
      end
      if (got.volt_ok !== e.volt_ok) begin
        $error("voltage_ok: expected %0d, got %0d", e.volt_ok, got.volt_ok);
        errors++;
      end
      if (got.temp_ok !== e.temp_ok) begin
        $error("temperature_ok: expected %0d, got %0d", e.temp_ok, got.temp_ok);
        errors++;
      end
      if (got.proc_ok !== e.proc_ok) begin
        $error("process_ok: expected %0d, got %0d", e.proc_ok, got.proc_ok);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [pdfi_pkg::VOLT_W-1:0] in_voltage_mv;
  logic signed [pdfi_pkg::TEMP_W-1:0] in_temperature_decideg;
  logic [pdfi_pkg::CORNER_W-1:0] in_process_corner;
  logic out_valid;
  logic out_ready;
  logic [pdfi_pkg::FACTOR_W-1:0] out_voltage_factor;
  logic [pdfi_pkg::FACTOR_W-1:0] out_temperature_factor;
  logic [pdfi_pkg::FACTOR_W-1:0] out_process_factor;
  logic out_voltage_ok;
  logic out_temperature_ok;
  logic out_process_ok;

  derating_ledger book;
  bit in_took;
  bit calm;
  int quiet_cycles;
  int sent;

  pvt_derating_factor_interpolator uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_voltage_mv(in_voltage_mv),
    .in_temperature_decideg(in_temperature_decideg),
    .in_process_corner(in_process_corner),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_voltage_factor(out_voltage_factor),
    .out_temperature_factor(out_temperature_factor),
    .out_process_factor(out_process_factor),
    .out_voltage_ok(out_voltage_ok),
    .out_temperature_ok(out_temperature_ok),
    .out_process_ok(out_process_ok)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // transfer monitor, sampled at the rising edge
  always @(posedge clk) begin
    in_took = rst_n && in_valid && in_ready;
    if (in_took)
      book.note_request(in_voltage_mv, in_temperature_decideg, in_process_corner);
    if (rst_n && out_valid && out_ready)
      book.check_factors('{out_voltage_factor, out_temperature_factor, out_process_factor,
                           out_voltage_ok, out_temperature_ok, out_process_ok});
    if (in_took || (rst_n && out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ready = calm || ($urandom_range(99) >= 28);
    end
  end

  initial begin
    do @(negedge clk); while (quiet_cycles < STALL_LIMIT);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [pdfi_pkg::VOLT_W-1:0] v,
                           input logic signed [pdfi_pkg::TEMP_W-1:0] t,
                           input logic [pdfi_pkg::CORNER_W-1:0] c);
    if (!calm) begin
      while ($urandom_range(99) < 28) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_voltage_mv = v;
    in_temperature_decideg = t;
    in_process_corner = c;
    do @(negedge clk); while (!in_took);
    sent++;
  endtask

  initial begin
    int edge_mv [20];
    int edge_dc [20];
    int kind;
    int v;
    int t;
    book = new();
    calm = 1'b0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_voltage_mv = '0;
    in_temperature_decideg = '0;
    in_process_corner = '0;
    edge_mv = '{0, 1079, 1080, 1100, 1120, 1200, 1319, 1320, 1321, 2047,
                1160, 1240, 1281, 1080, 1320, 1, 1024, 1199, 1201, 2046};
    edge_dc = '{-2048, -251, -250, -200, 0, 75, 1249, 1250, 1251, 2047,
                -1, -150, 150, 1, 1150, -2047, 1000, 2046, 1251, -400};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: table ends, breakpoints, out of span, all corners
    foreach (edge_mv[i])
      send_item(pdfi_pkg::VOLT_W'(edge_mv[i]), pdfi_pkg::TEMP_W'(edge_dc[i]),
                pdfi_pkg::CORNER_W'(i % 4));

    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 300);
      if (n == 350) begin
        in_valid = 1'b0;
        while (book.owed_factors.size() != 0) @(negedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        v = 1080 + $urandom_range(240);
        t = -250 + $urandom_range(1500);
      end else if (kind < 75) begin
        v = MV_BP[$urandom_range(MV_PTS - 1)] + $urandom_range(2) - 1;
        t = DC_BP[$urandom_range(DC_PTS - 1)] + $urandom_range(2) - 1;
      end else begin
        v = $urandom_range(2047);
        t = $urandom_range(4095);
      end
      send_item(v[pdfi_pkg::VOLT_W-1:0], t[pdfi_pkg::TEMP_W-1:0],
                pdfi_pkg::CORNER_W'($urandom_range(3)));
    end
    in_valid = 1'b0;
    calm = 1'b0;

    while (book.owed_factors.size() != 0) @(negedge clk);
    repeat (pdfi_pkg::LANE_LAT + 10) @(negedge clk);

    $display("summary: %0d items sent, %0d results checked, %0d mismatches",
             sent, book.checked, book.errors);
    $display("summary: voltage in span %0d, temperature in span %0d, invalid corners %0d",
             book.volt_hits, book.temp_hits, book.bad_corners);
    if (book.errors == 0 && book.owed_factors.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: pvt_derating_factor_interpolator.f
rtl/pdfi_pkg.sv
rtl/pdfi_front.sv
rtl/pdfi_queue.sv
rtl/pdfi_lane.sv
rtl/pdfi_back.sv
rtl/pvt_derating_factor_interpolator.sv
bench/pvt_derating_factor_interpolator_test.sv
